[hw/rtl/dmf_pkg.sv]
// ----------------------------------------------------------------------------
// dmf_pkg - shared types and constants of the duplicate message filter
// Identity record, opcodes, controller states and the chain control group.
// ----------------------------------------------------------------------------
package dmf_pkg;

   localparam int HISTORY_DEPTH_DEFAULT = 16;
   localparam int TYPE_W                = 4;
   localparam int SEQ_W                 = 32;
   localparam int MASK_W                = 16;

   localparam logic [MASK_W-1:0] MASK_RESET = 16'h000F;

   localparam logic OP_CHECK  = 1'b0;
   localparam logic OP_RECORD = 1'b1;

   typedef struct packed {
      logic [TYPE_W-1:0] kind;
      logic [SEQ_W-1:0]  seq;
   } ident_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESOLVE
   } state_type;

   typedef struct packed {
      logic launch;   // lookup token enters the first cell
      logic shift;    // history row moves one cell, new identity in cell 0
   } chain_ctl_type;

endpackage

[hw/rtl/dmf_cell.sv]
// ----------------------------------------------------------------------------
// dmf_cell - one history cell of the duplicate message filter
// Holds one identity and passes a lookup token on with its hit flag.
// ----------------------------------------------------------------------------
module dmf_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               shift,
   input  logic               filled,
   input  dmf_pkg::ident_type prev_entry,
   output dmf_pkg::ident_type next_entry,
   input  logic               prev_tok_valid,
   input  dmf_pkg::ident_type prev_tok_id,
   input  logic               prev_tok_hit,
   output logic               next_tok_valid,
   output dmf_pkg::ident_type next_tok_id,
   output logic               next_tok_hit
);
   import dmf_pkg::*;

   ident_type entry_ff;
   ident_type entry_in;
   logic      tok_valid_ff;
   ident_type tok_id_ff;
   logic      tok_hit_ff;
   logic      tok_hit_in;

   always_comb begin
      entry_in   = shift ? prev_entry : entry_ff;
      // unfilled cells never match
      tok_hit_in = prev_tok_hit | (filled && (entry_ff == prev_tok_id));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_valid_ff <= 1'b0;
      end else begin
         tok_valid_ff <= prev_tok_valid;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff   <= entry_in;
      tok_id_ff  <= prev_tok_id;
      tok_hit_ff <= tok_hit_in;
   end

   assign next_entry     = entry_ff;
   assign next_tok_valid = tok_valid_ff;
   assign next_tok_id    = tok_id_ff;
   assign next_tok_hit   = tok_hit_ff;

endmodule

[hw/rtl/dmf_ctrl.sv]
// ----------------------------------------------------------------------------
// dmf_ctrl - sequencer of the duplicate message filter
// Takes requests, launches lookups, keeps fill count, mask and result register.
// ----------------------------------------------------------------------------
module dmf_ctrl #(
   parameter int HISTORY_DEPTH = dmf_pkg::HISTORY_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_opcode,
   input  logic [dmf_pkg::TYPE_W-1:0] req_message_type,
   input  logic [dmf_pkg::SEQ_W-1:0]  req_sequence_number,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [dmf_pkg::MASK_W-1:0] csr_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_is_duplicate,
   output logic                       rsp_was_recorded,
   input  logic                       tail_valid,
   input  logic                       tail_hit,
   output dmf_pkg::chain_ctl_type     ctl,
   output dmf_pkg::ident_type         query,
   output logic [HISTORY_DEPTH-1:0]   filled
);
   import dmf_pkg::*;

   localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(HISTORY_DEPTH);

   state_type         state_ff, state_in;
   ident_type         query_ff;
   logic              opcode_ff;
   logic              hit_ff, hit_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [MASK_W-1:0] mask_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_dup_ff, rsp_dup_in;
   logic              rsp_rec_ff, rsp_rec_in;
   logic              accept;
   logic              out_free;
   logic              record;

   assign csr_ready = 1'b1;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign record    = (opcode_ff == OP_RECORD) && !hit_ff && mask_ff[query_ff.kind];

   always_comb begin
      state_in     = state_ff;
      hit_in       = hit_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_dup_in   = rsp_dup_ff;
      rsp_rec_in   = rsp_rec_ff;
      req_stall    = 1'b1;
      ctl.launch   = 1'b0;
      ctl.shift    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            ctl.launch = req_valid;
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (tail_valid) begin
               hit_in   = tail_hit;
               state_in = ST_RESOLVE;
            end
         end
         ST_RESOLVE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_dup_in   = hit_ff;
               rsp_rec_in   = record;
               ctl.shift    = record;
               if (record && (count_ff != CNT_FULL)) begin
                  count_in = count_ff + CNT_W'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
         filled[i] = (count_ff > CNT_W'(i));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         mask_ff      <= MASK_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            mask_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         query_ff.kind <= req_message_type;
         query_ff.seq  <= req_sequence_number;
         opcode_ff     <= req_opcode;
      end
      hit_ff     <= hit_in;
      rsp_dup_ff <= rsp_dup_in;
      rsp_rec_ff <= rsp_rec_in;
   end

   assign query            = query_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_duplicate = rsp_dup_ff;
   assign rsp_was_recorded = rsp_rec_ff;

endmodule

[hw/rtl/duplicate_message_filter_top.sv]
// ----------------------------------------------------------------------------
// duplicate_message_filter_top - duplicate message filter
// Row of history cells searched by a traveling lookup token.
// ----------------------------------------------------------------------------
// Each request carries a message type and sequence number; the block answers
// whether that pair is held in the last HISTORY_DEPTH recorded identities and,
// for a record request that misses and whose type bit is set in the mask,
// shifts the new pair into cell 0, dropping the oldest once the row is full.
// One request is in work at a time: it is taken while cell 0 compares, the
// lookup token walks the rest of the cell row, the hit is latched at the tail,
// and the resolve step loads the result register. A new request is taken once
// the result register is loaded, even while that result still waits on
// rsp_stall; a resolve waits until the result register is free. The mask is
// written over the csr port, always ready; the user writes it only while the
// block is idle, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module duplicate_message_filter_top #(
   parameter int HISTORY_DEPTH = dmf_pkg::HISTORY_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_opcode,
   input  logic [dmf_pkg::TYPE_W-1:0] req_message_type,
   input  logic [dmf_pkg::SEQ_W-1:0]  req_sequence_number,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [dmf_pkg::MASK_W-1:0] csr_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_is_duplicate,
   output logic                       rsp_was_recorded
);
   import dmf_pkg::*;

   chain_ctl_type            ctl;
   ident_type                query;
   logic [HISTORY_DEPTH-1:0] filled;

   // token links: index i feeds cell i, index HISTORY_DEPTH is the tail
   logic [HISTORY_DEPTH:0]   tok_valid;
   logic [HISTORY_DEPTH:0]   tok_hit;
   ident_type                tok_id     [HISTORY_DEPTH];
   ident_type                entry_link [HISTORY_DEPTH];

   dmf_ctrl #(
      .HISTORY_DEPTH(HISTORY_DEPTH)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_message_type   (req_message_type),
      .req_sequence_number(req_sequence_number),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_data           (csr_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_is_duplicate   (rsp_is_duplicate),
      .rsp_was_recorded   (rsp_was_recorded),
      .tail_valid         (tok_valid[HISTORY_DEPTH]),
      .tail_hit           (tok_hit[HISTORY_DEPTH]),
      .ctl                (ctl),
      .query              (query),
      .filled             (filled)
   );

   // Token enters with the request fields straight off the port; the new
   // identity for a record comes from the latched query.
   assign tok_valid[0]   = ctl.launch;
   assign tok_hit[0]     = 1'b0;
   assign tok_id[0].kind = req_message_type;
   assign tok_id[0].seq  = req_sequence_number;
   assign entry_link[0]  = query;

   for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
      if (i < HISTORY_DEPTH - 1) begin : g_mid
         dmf_cell u_cell (
            .clock         (clock),
            .reset         (reset),
            .shift         (ctl.shift),
            .filled        (filled[i]),
            .prev_entry    (entry_link[i]),
            .next_entry    (entry_link[i+1]),
            .prev_tok_valid(tok_valid[i]),
            .prev_tok_id   (tok_id[i]),
            .prev_tok_hit  (tok_hit[i]),
            .next_tok_valid(tok_valid[i+1]),
            .next_tok_id   (tok_id[i+1]),
            .next_tok_hit  (tok_hit[i+1])
         );
      end else begin : g_tail
         // oldest entry drops off the end of the row
         dmf_cell u_cell (
            .clock         (clock),
            .reset         (reset),
            .shift         (ctl.shift),
            .filled        (filled[i]),
            .prev_entry    (entry_link[i]),
            .next_entry    (),
            .prev_tok_valid(tok_valid[i]),
            .prev_tok_id   (tok_id[i]),
            .prev_tok_hit  (tok_hit[i]),
            .next_tok_valid(tok_valid[i+1]),
            .next_tok_id   (),
            .next_tok_hit  (tok_hit[i+1])
         );
      end
   end

`ifndef SYNTHESIS
   // a recorded identity was never a duplicate
   a_rec_not_dup: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_is_duplicate && rsp_was_recorded))
      else $error("recorded a duplicate identity");

   // at most one lookup token in the cell row
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_valid[HISTORY_DEPTH:1]))
      else $error("more than one lookup token in flight");

   // a lookup starts only on an empty row
   a_launch_empty: assert property (@(posedge clock) disable iff (reset)
      ctl.launch |-> (tok_valid[HISTORY_DEPTH:1] == '0))
      else $error("lookup launched while another is in flight");

   // the history never moves while a token walks it
   a_shift_quiet: assert property (@(posedge clock) disable iff (reset)
      ctl.shift |-> (tok_valid[HISTORY_DEPTH:1] == '0))
      else $error("history shifted during a lookup");
`endif

endmodule

[sim/duplicate_message_filter_checker.sv]
// ----------------------------------------------------------------------------
// duplicate_message_filter_checker - scoreboard for the duplicate filter
// Tracks the identity history on every request transfer and compares results.
// ----------------------------------------------------------------------------
module duplicate_message_filter_checker #(
   parameter int HISTORY_DEPTH = dmf_pkg::HISTORY_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic                       req_opcode,
   input  logic [dmf_pkg::TYPE_W-1:0] req_message_type,
   input  logic [dmf_pkg::SEQ_W-1:0]  req_sequence_number,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [dmf_pkg::MASK_W-1:0] csr_data,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic                       rsp_is_duplicate,
   input  logic                       rsp_was_recorded,
   output int                         mismatches,
   output int                         verdicts_pending
);
   import dmf_pkg::*;

   typedef struct packed {
      logic is_duplicate;
      logic was_recorded;
   } verdict_type;

   ident_type         history [HISTORY_DEPTH];
   int unsigned       next_slot;
   int unsigned       filled;
   logic [MASK_W-1:0] type_mask;
   verdict_type       verdicts_due [$];
   verdict_type       due;

   // lookup over filled entries only, then store a record request when new and type enabled
   function automatic verdict_type screen_message(input logic              op,
                                                  input logic [TYPE_W-1:0] kind,
                                                  input logic [SEQ_W-1:0]  seq);
      verdict_type v;
      int          i;
      v.is_duplicate = 1'b0;
      v.was_recorded = 1'b0;
      for (i = 0; i < filled; i++) begin
         if (history[i].kind == kind && history[i].seq == seq)
            v.is_duplicate = 1'b1;
      end
      if (op == OP_RECORD && !v.is_duplicate && type_mask[kind]) begin
         history[next_slot].kind = kind;
         history[next_slot].seq  = seq;
         next_slot = (next_slot == HISTORY_DEPTH - 1) ? 0 : next_slot + 1;
         if (filled < HISTORY_DEPTH)
            filled++;
         v.was_recorded = 1'b1;
      end
      return v;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         next_slot = 0;
         filled    = 0;
         type_mask = MASK_RESET;
         verdicts_due.delete();
      end else begin
         if (csr_valid && csr_ready)
            type_mask = csr_data;
         if (rsp_valid && !rsp_stall) begin
            if (verdicts_due.size() == 0) begin
               mismatches++;
               $display("%0t: result transfer with nothing expected (dup %b rec %b)",
                        $time, rsp_is_duplicate, rsp_was_recorded);
            end else begin
               due = verdicts_due.pop_front();
               if (rsp_is_duplicate !== due.is_duplicate) begin
                  mismatches++;
                  $display("%0t: is_duplicate expected %b got %b",
                           $time, due.is_duplicate, rsp_is_duplicate);
               end
               if (rsp_was_recorded !== due.was_recorded) begin
                  mismatches++;
                  $display("%0t: was_recorded expected %b got %b",
                           $time, due.was_recorded, rsp_was_recorded);
               end
            end
         end
         if (req_valid && !req_stall)
            verdicts_due.push_back(screen_message(req_opcode, req_message_type,
                                                  req_sequence_number));
      end
      verdicts_pending = verdicts_due.size();
   end

endmodule

[sim/duplicate_message_filter_top_tb.sv]
// ----------------------------------------------------------------------------
// duplicate_message_filter_top_tb - testbench for the duplicate message filter
// Directed and random message streams under changing type masks and flow
// control; results are judged by the checker instantiated beside the block.
// ----------------------------------------------------------------------------
module duplicate_message_filter_top_tb;
   import dmf_pkg::*;

   localparam int HISTORY_DEPTH   = HISTORY_DEPTH_DEFAULT;
   localparam int HALF_PERIOD     = 6;
   localparam int LIMIT_CYCLES    = 400000;
   // long receiver hold-off; far beyond the two requests the block can absorb
   localparam int RSP_HOLD_CYCLES = 300;
   // settle time after the last drain, longer than one request in flight
   localparam int DRAIN_CYCLES    = HISTORY_DEPTH + 8;
   localparam int RECENT_KEEP     = 24;
   localparam int KIND_MAX        = (1 << TYPE_W) - 1;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid;
   logic               req_stall;
   logic               req_opcode;
   logic [TYPE_W-1:0]  req_message_type;
   logic [SEQ_W-1:0]   req_sequence_number;
   logic               csr_valid;
   logic               csr_ready;
   logic [MASK_W-1:0]  csr_data;
   logic               rsp_valid;
   logic               rsp_stall;
   logic               rsp_is_duplicate;
   logic               rsp_was_recorded;

   int                 mismatches;
   int                 verdicts_pending;

   // flow control knobs, percent per cycle
   int                 req_idle_pct    = 0;
   int                 rsp_stall_pct   = 0;
   logic               rsp_hold_wanted = 1'b0;
   logic               rsp_hold_done   = 1'b0;

   // identities sent lately; replaying them is what produces duplicates
   ident_type          recent_ids [$];

   always #HALF_PERIOD clock = ~clock;

   duplicate_message_filter_top #(
      .HISTORY_DEPTH(HISTORY_DEPTH)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_message_type   (req_message_type),
      .req_sequence_number(req_sequence_number),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_data           (csr_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_is_duplicate   (rsp_is_duplicate),
      .rsp_was_recorded   (rsp_was_recorded)
   );

   duplicate_message_filter_checker #(
      .HISTORY_DEPTH(HISTORY_DEPTH)
   ) checker_i (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_message_type   (req_message_type),
      .req_sequence_number(req_sequence_number),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_data           (csr_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_is_duplicate   (rsp_is_duplicate),
      .rsp_was_recorded   (rsp_was_recorded),
      .mismatches         (mismatches),
      .verdicts_pending   (verdicts_pending)
   );

   // One request transfer. Idle cycles come first (valid low), then the
   // payload is offered and held until a clock edge sees stall low. Returns
   // on the accepting edge with valid still high, so a following call can
   // keep it high without a second assignment in this time step.
   task automatic send_message(input logic              op,
                               input logic [TYPE_W-1:0] kind,
                               input logic [SEQ_W-1:0]  seq);
      ident_type id;
      id.kind = kind;
      id.seq  = seq;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_opcode          <= op;
      req_message_type    <= kind;
      req_sequence_number <= seq;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      recent_ids.push_back(id);
      if (recent_ids.size() > RECENT_KEEP)
         void'(recent_ids.pop_front());
   endtask

   // Drop valid and wait until every expected result has been transferred.
   // Each request yields exactly one result, so the block is idle then.
   // The checker refreshes its count at each edge; the task waits for an edge
   // first so the count already holds the last request transfer.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (verdicts_pending != 0)
         @(posedge clock);
   endtask

   // Mask write; only issued with the block drained.
   task automatic write_mask(input logic [MASK_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random message mix: replays of recent identities (duplicates or evicted
   // entries), a small sequence pool near both ends of the range so that
   // collisions are frequent, and fully random sequence numbers.
   task automatic random_message();
      logic              op;
      logic [TYPE_W-1:0] kind;
      logic [SEQ_W-1:0]  seq;
      ident_type         id;
      int unsigned       pick;
      pick = $urandom_range(99);
      op   = ($urandom_range(99) < 70) ? OP_RECORD : OP_CHECK;
      if (pick < 40 && recent_ids.size() != 0) begin
         id   = recent_ids[$urandom_range(recent_ids.size() - 1)];
         kind = id.kind;
         seq  = id.seq;
      end else if (pick < 80) begin
         kind = TYPE_W'($urandom_range(KIND_MAX));
         seq  = $urandom_range(15);
         if ($urandom_range(1) != 0)
            seq = ~seq;
      end else begin
         kind = TYPE_W'($urandom_range(KIND_MAX));
         seq  = $urandom;
      end
      send_message(op, kind, seq);
   endtask

   // Drain, load a new mask and flow-control mix, then run random traffic.
   task automatic run_phase(input int                count,
                            input logic [MASK_W-1:0] mask,
                            input int                idle_pct,
                            input int                stall_pct);
      wait_drained();
      write_mask(mask);
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (count)
         random_message();
   endtask

   // Receiver side. Random stall per cycle, except for one long hold-off in
   // the pressure phase, counted here while the sender keeps offering.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_wanted && !rsp_hold_done) begin
            rsp_stall <= 1'b1;
            repeat (RSP_HOLD_CYCLES)
               @(posedge clock);
            rsp_hold_done = 1'b1;
         end
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Run limit: several times the slowest legal run.
   initial begin
      #(2 * HALF_PERIOD * LIMIT_CYCLES);
      $display("** duplicate_message_filter_top: FAILED **");
      $finish;
   end

   initial begin
      req_valid           = 1'b0;
      req_opcode          = OP_CHECK;
      req_message_type    = '0;
      req_sequence_number = '0;
      csr_valid           = 1'b0;
      csr_data            = '0;
      repeat (3)
         @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, reset mask (types 0..3 recordable).
      send_message(OP_CHECK,  4'd0,  32'h0000_0000);  // empty history: never a duplicate
      send_message(OP_RECORD, 4'd0,  32'h0000_0000);  // first store
      send_message(OP_CHECK,  4'd0,  32'h0000_0000);  // check only hits, no store
      send_message(OP_RECORD, 4'd0,  32'h0000_0000);  // duplicate on record: not stored
      send_message(OP_RECORD, 4'd15, 32'hFFFF_FFFF);  // type not enabled
      send_message(OP_RECORD, 4'd3,  32'hFFFF_FFFF);  // top sequence, enabled type
      send_message(OP_CHECK,  4'd15, 32'hFFFF_FFFF);  // same sequence, other type: miss
      // fill the history and wrap the write slot past the first two entries
      for (int n = 1; n <= HISTORY_DEPTH; n++)
         send_message(OP_RECORD, 4'd1, n);
      send_message(OP_CHECK,  4'd0,  32'h0000_0000);  // oldest entry was overwritten
      send_message(OP_CHECK,  4'd3,  32'hFFFF_FFFF);  // second entry overwritten too

      // Random phases, one mask each, extremes included.
      run_phase(200, 16'hFFFF,           0,  0);   // back-to-back, no stalls
      run_phase(180, 16'h0000,           58, 0);   // sender idles, nothing recordable
      run_phase(200, MASK_W'($urandom),  0,  58);  // receiver stalls
      run_phase(200, MASK_W'($urandom),  26, 26);  // both sides idle

      // Pressure: receiver holds off while the sender offers back-to-back,
      // so the result register and the next request fill and req_stall rises.
      wait_drained();
      write_mask(16'hFFFF);
      req_idle_pct    = 0;
      rsp_stall_pct   = 0;
      rsp_hold_wanted = 1'b1;
      repeat (145)
         random_message();

      wait_drained();
      repeat (DRAIN_CYCLES)
         @(posedge clock);
      if (mismatches == 0 && verdicts_pending == 0)
         $display("** duplicate_message_filter_top: PASSED **");
      else
         $display("** duplicate_message_filter_top: FAILED **");
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/dmf_pkg.sv
hw/rtl/dmf_cell.sv
hw/rtl/dmf_ctrl.sv
hw/rtl/duplicate_message_filter_top.sv
sim/duplicate_message_filter_checker.sv
sim/duplicate_message_filter_top_tb.sv
